// File: sv/sgi_pkg.sv
`timescale 1ns / 1ps
package sgi_pkg;
	localparam int CW = 16;           // coordinate width
	localparam int DW = CW + 1;       // coordinate difference
	localparam int PW = 2 * DW;       // difference product
	localparam int XW = PW + 1;       // cross product
	localparam int MW = XW + DW;      // cross times difference
	localparam int NW = MW + 1;       // unsigned dividend / remainder
	localparam int QB = CW + 2;       // quotient bits kept; larger means saturate
	localparam int SW = QB + 2;       // signed sum width
	localparam int LATENCY = 6 + QB;  // accept edge to done sample

	typedef struct packed {
		logic          valid;
		logic [NW-1:0] rem_x;
		logic [NW-1:0] rem_y;
		logic [NW-1:0] dsh;
		logic [QB-1:0] q_x;
		logic [QB-1:0] q_y;
		logic          neg_x;
		logic          neg_y;
		logic          ovf_x;
		logic          ovf_y;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic          hit;
		logic          par;
	} cell_t;
endpackage

// File: sv/sgi_front.sv
`timescale 1ns / 1ps
module sgi_front import sgi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	input  logic signed [CW-1:0] cx,
	input  logic signed [CW-1:0] cy,
	input  logic signed [CW-1:0] ex,
	input  logic signed [CW-1:0] ey,
	output cell_t                head
);
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] px_s1, py_s1, qx_s1, qy_s1, rx_s1, ry_s1;
	logic signed [CW-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4;
	logic signed [DW-1:0] px_s2, py_s2, px_s3, py_s3;
	logic signed [PW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [XW-1:0] d_s3, tn_s3, un_s3, d_s4;
	logic signed [MW-1:0] nx_s4, ny_s4;
	logic hit_s4, par_s4;
	logic t_in, u_in;
	logic [NW-1:0] absn_x, absn_y, absd;

	// s5: magnitudes, quotient overflow, divider load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			head <= '0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			head.valid <= v_s4;
			head.rem_x <= absn_x;
			head.rem_y <= absn_y;
			head.dsh   <= absd << (QB - 1);
			head.q_x   <= '0;
			head.q_y   <= '0;
			head.neg_x <= nx_s4[MW-1] ^ d_s4[XW-1];
			head.neg_y <= ny_s4[MW-1] ^ d_s4[XW-1];
			head.ovf_x <= absn_x >= (absd << QB);
			head.ovf_y <= absn_y >= (absd << QB);
			head.ax    <= ax_s4;
			head.ay    <= ay_s4;
			head.hit   <= hit_s4;
			head.par   <= par_s4;
		end
	end

	// in [0,1] test on numerator against d, exact
	always_comb begin
		if (!d_s3[XW-1]) begin
			t_in = !tn_s3[XW-1] && (tn_s3 <= d_s3);
			u_in = !un_s3[XW-1] && (un_s3 <= d_s3);
		end else begin
			t_in = (tn_s3 <= 0) && (tn_s3 >= d_s3);
			u_in = (un_s3 <= 0) && (un_s3 >= d_s3);
		end
	end

	assign absn_x = nx_s4[MW-1] ? NW'(-$signed({nx_s4[MW-1], nx_s4})) : NW'(nx_s4);
	assign absn_y = ny_s4[MW-1] ? NW'(-$signed({ny_s4[MW-1], ny_s4})) : NW'(ny_s4);
	assign absd   = d_s4[XW-1] ? NW'(-$signed({d_s4[XW-1], d_s4})) : NW'(d_s4);

	always_ff @(posedge clk) begin
		px_s1 <= DW'(bx) - DW'(ax);
		py_s1 <= DW'(by) - DW'(ay);
		qx_s1 <= DW'(ex) - DW'(cx);
		qy_s1 <= DW'(ey) - DW'(cy);
		rx_s1 <= DW'(cx) - DW'(ax);
		ry_s1 <= DW'(cy) - DW'(ay);
		ax_s1 <= ax; ay_s1 <= ay;
		// s2: six products
		m0_s2 <= px_s1 * qy_s1;
		m1_s2 <= py_s1 * qx_s1;
		m2_s2 <= rx_s1 * qy_s1;
		m3_s2 <= ry_s1 * qx_s1;
		m4_s2 <= rx_s1 * py_s1;
		m5_s2 <= ry_s1 * px_s1;
		px_s2 <= px_s1; py_s2 <= py_s1; ax_s2 <= ax_s1; ay_s2 <= ay_s1;
		// s3: cross products
		d_s3  <= XW'(m0_s2) - XW'(m1_s2);
		tn_s3 <= XW'(m2_s2) - XW'(m3_s2);
		un_s3 <= XW'(m4_s2) - XW'(m5_s2);
		px_s3 <= px_s2; py_s3 <= py_s2; ax_s3 <= ax_s2; ay_s3 <= ay_s2;
		// s4: dividends and hit
		nx_s4  <= tn_s3 * px_s3;
		ny_s4  <= tn_s3 * py_s3;
		d_s4   <= d_s3;
		par_s4 <= (d_s3 == '0);
		hit_s4 <= (d_s3 != '0) && t_in && u_in;
		ax_s4 <= ax_s3; ay_s4 <= ay_s3;
	end
endmodule

// File: sv/sgi_div_cell.sv
`timescale 1ns / 1ps
module sgi_div_cell import sgi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t prev,
	output cell_t next
);
	logic ge_x, ge_y;
	assign ge_x = prev.rem_x >= prev.dsh;
	assign ge_y = prev.rem_y >= prev.dsh;

	// one restoring quotient bit per lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next <= '0;
		end else begin
			next.valid <= prev.valid;
			next.rem_x <= ge_x ? prev.rem_x - prev.dsh : prev.rem_x;
			next.rem_y <= ge_y ? prev.rem_y - prev.dsh : prev.rem_y;
			next.q_x   <= {prev.q_x[QB-2:0], ge_x};
			next.q_y   <= {prev.q_y[QB-2:0], ge_y};
			next.dsh   <= prev.dsh >> 1;
			next.neg_x <= prev.neg_x;
			next.neg_y <= prev.neg_y;
			next.ovf_x <= prev.ovf_x;
			next.ovf_y <= prev.ovf_y;
			next.ax    <= prev.ax;
			next.ay    <= prev.ay;
			next.hit   <= prev.hit;
			next.par   <= prev.par;
		end
	end
endmodule

// File: sv/sgi_back.sv
`timescale 1ns / 1ps
module sgi_back import sgi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_t                tail,
	output logic                 done,
	output logic                 hit,
	output logic                 parallel,
	output logic signed [CW-1:0] cross_x,
	output logic signed [CW-1:0] cross_y,
	output logic                 clipped
);
	localparam logic signed [SW-1:0] CMAX = SW'((1 << (CW - 1)) - 1);
	localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

	logic signed [SW-1:0] sx, sy, qx, qy;
	logic signed [CW-1:0] ox, oy;
	logic cx, cy;

	assign qx = tail.neg_x ? -$signed(SW'(tail.q_x)) : $signed(SW'(tail.q_x));
	assign qy = tail.neg_y ? -$signed(SW'(tail.q_y)) : $signed(SW'(tail.q_y));
	assign sx = SW'($signed(tail.ax)) + qx;
	assign sy = SW'($signed(tail.ay)) + qy;

	always_comb begin
		cx = 1'b1;
		if (tail.ovf_x) ox = tail.neg_x ? CMIN[CW-1:0] : CMAX[CW-1:0];
		else if (sx > CMAX) ox = CMAX[CW-1:0];
		else if (sx < CMIN) ox = CMIN[CW-1:0];
		else begin
			ox = sx[CW-1:0];
			cx = 1'b0;
		end
		cy = 1'b1;
		if (tail.ovf_y) oy = tail.neg_y ? CMIN[CW-1:0] : CMAX[CW-1:0];
		else if (sy > CMAX) oy = CMAX[CW-1:0];
		else if (sy < CMIN) oy = CMIN[CW-1:0];
		else begin
			oy = sy[CW-1:0];
			cy = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		parallel <= tail.par;
		hit      <= tail.hit;
		cross_x  <= tail.par ? '0 : ox;
		cross_y  <= tail.par ? '0 : oy;
		clipped  <= !tail.par && (cx || cy);
	end
endmodule

// File: sv/segment_intersection_unit.sv
`timescale 1ns / 1ps
// channel   ports                                          handshake
// command   start, first_*/second_* (8 x 16b signed)       start & !busy
// result    hit, parallel, cross_x, cross_y, clipped       done, one cycle
//
// One word accepted per cycle; busy is held low since nothing is shared.
// Path from accept to done: 5 front stages, 18 divider cells and one
// output register; the divider chain resolves one quotient
// bit per cell. Reset clears the valid bits and the chain registers;
// results cannot be stalled.
module segment_intersection_unit import sgi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] first_start_x,
	input  logic signed [CW-1:0] first_start_y,
	input  logic signed [CW-1:0] first_end_x,
	input  logic signed [CW-1:0] first_end_y,
	input  logic signed [CW-1:0] second_start_x,
	input  logic signed [CW-1:0] second_start_y,
	input  logic signed [CW-1:0] second_end_x,
	input  logic signed [CW-1:0] second_end_y,
	output logic                 done,
	output logic                 hit,
	output logic                 parallel,
	output logic signed [CW-1:0] cross_x,
	output logic signed [CW-1:0] cross_y,
	output logic                 clipped
);
	cell_t chain [QB+1];

	assign busy = 1'b0;

	// differences, cross products, dividends, magnitudes
	sgi_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.ax(first_start_x), .ay(first_start_y),
		.bx(first_end_x), .by(first_end_y),
		.cx(second_start_x), .cy(second_start_y),
		.ex(second_end_x), .ey(second_end_y),
		.head(chain[0])
	);

	// restoring divider: cell k resolves quotient bit QB-1-k for x and y
	for (genvar k = 0; k < QB; k++) begin : g_cell
		sgi_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .prev(chain[k]), .next(chain[k+1])
		);
	end

	// sign, add start point, saturate, parallel override
	sgi_back u_back (
		.clk(clk), .arst_n(arst_n), .tail(chain[QB]),
		.done(done), .hit(hit), .parallel(parallel),
		.cross_x(cross_x), .cross_y(cross_y), .clipped(clipped)
	);
endmodule

// File: sv/sgi_checker.sv
`timescale 1ns / 1ps
module sgi_checker import sgi_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic                 hit,
	input logic                 parallel,
	input logic signed [CW-1:0] cross_x,
	input logic signed [CW-1:0] cross_y,
	input logic                 clipped
);
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done) else $error("missing result");
	a_par_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		done && parallel |-> !hit) else $error("parallel with hit");
	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && parallel |-> cross_x == '0 && cross_y == '0 && !clipped)
		else $error("parallel point not zero");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
endmodule

bind segment_intersection_unit sgi_checker u_sgi_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.hit(hit), .parallel(parallel), .cross_x(cross_x), .cross_y(cross_y),
	.clipped(clipped)
);
